>>> rtl/gdds_pkg.sv
// shared types, constants and calendar helpers for the gregorian date day stepper
package gdds_pkg;

  // field widths
  localparam int KIND_W  = 2;
  localparam int AMT_W   = 16;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int WD_W    = 4;

  // packed channel widths
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = KIND_W;
  localparam int OUT_TDATA_W = 32;

  // default upper bound of the calendar
  localparam int unsigned GDDS_MAX_YEAR = 9999;

  // shared multiplier geometry
  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // remaining day count, wide enough for 32768 years of 365 days
  localparam int CNT_W = 24;

  // year position within the 400 year cycle
  localparam int YMOD_W = 9;

  // multiplier constants: reciprocals and shift scales
  localparam logic [MUL_B_W-1:0] RECIP_100   = 18'd5243;    // x / 100 = (x * c) >> 19
  localparam logic [MUL_B_W-1:0] RECIP_7     = 18'd149797;  // x / 7   = (x * c) >> 20
  localparam logic [MUL_B_W-1:0] SCALE_DAY   = 18'd1;
  localparam logic [MUL_B_W-1:0] SCALE_MONTH = 18'd30;
  localparam logic [MUL_B_W-1:0] SCALE_YEAR  = 18'd365;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_DAYS   = 2'd1,
    KIND_MONTHS = 2'd2,
    KIND_YEARS  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_Q400,
    S_LD_MOD,
    S_LD_P100,
    S_LD_P400,
    S_LD_S7,
    S_LD_WD,
    S_SH_MUL,
    S_SH_CNT,
    S_SH_STEP,
    S_DONE
  } state_t;

  // leap year from the year's position in the 400 year cycle
  function automatic logic leap_of_mod400(input logic [YMOD_W-1:0] ym);
    return (ym[1:0] == 2'b00) && (ym != 9'd100) && (ym != 9'd200) && (ym != 9'd300);
  endfunction

  // month length, zero for months that do not exist
  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  // days in the year before the first of the month
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [8:0] c;
    unique case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

endpackage

>>> rtl/gdds_mul.sv
// shared unsigned multiplier with registered product
module gdds_mul (
  input  logic                        clk,
  input  logic [gdds_pkg::MUL_A_W-1:0] a,
  input  logic [gdds_pkg::MUL_B_W-1:0] b,
  output logic [gdds_pkg::MUL_P_W-1:0] p
);
  import gdds_pkg::*;

  logic [MUL_P_W-1:0] p_r;

  // product register, operands change each cycle under the sequencer
  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign p = p_r;

endmodule

>>> rtl/gregorian_date_day_stepper.sv
// top level of the gregorian date day stepper
//
// Holds one date (day, month, year) and answers every input transfer with
// exactly one result transfer. An input with kind load replaces the held date
// if it is a valid calendar date, otherwise flags load_rejected and keeps it.
// The other kinds move the date by amount days, amount * 30 days or
// amount * 365 days, stopping at 1/1/1 or 31/12/MAX_YEAR with saturated set.
// Each result carries the date, its leap flag and the weekday (2 Monday to
// 8 Sunday).
// A valid load runs the Q400, MOD, P100, P400, S7 and WD steps; a rejected
// load ends after the P100 check. A shift scales the amount, then steps (at
// most about 3.65 million days). The next input transfer can come in the cycle
// after the result is registered.
// The day stepper walks the calendar one day per cycle; the sequencer and a
// single shared multiplier do the shift scaling and the weekday of a load.
// One item is in work at a time: in_tready is high only while idle.
// A finished result waits in the output register when out_tready is low and
// the block holds the next item until that register is free.
// Reset sets the date to 1/1/1 (a Monday) and drops any result in flight.
module gregorian_date_day_stepper #(
  parameter int unsigned MAX_YEAR = gdds_pkg::GDDS_MAX_YEAR
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // amount[15:0], load_day[20:16], load_month[24:21], load_year[38:25], zero pad
  input  logic [gdds_pkg::IN_TDATA_W-1:0]    in_tdata,
  // kind[1:0]
  input  logic [gdds_pkg::IN_TUSER_W-1:0]    in_tuser,
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // cur_day[4:0], cur_month[8:5], cur_year[22:9], is_leap[23], weekday[27:24],
  // load_rejected[28], saturated[29], zero pad
  output logic [gdds_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import gdds_pkg::*;

  localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

  state_t state_r, state_nxt;

  // captured input item
  kind_t              kind_r;
  logic [AMT_W-1:0]   amount_r;
  logic [DAY_W-1:0]   ld_r;
  logic [MONTH_W-1:0] lm_r;
  logic [YEAR_W-1:0]  ly_r;

  // held date and its derived position
  logic [DAY_W-1:0]   day_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  year_r;
  logic [YMOD_W-1:0]  ymod_r;
  logic [2:0]         wd_r;

  // load and shift working registers
  logic [YMOD_W-1:0]  ymod_ld_r;
  logic [7:0]         p100_r;
  logic [14:0]        s_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               rej_r;
  logic               sat_r;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  gdds_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // handshake terms
  logic in_xfer;
  logic out_free;
  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // load arithmetic
  logic [YEAR_W-1:0]  p_ld;
  logic [5:0]         q400;
  logic [YEAR_W-1:0]  q400x400;
  logic [YMOD_W-1:0]  ymod_ld;
  logic               leap_ld;
  logic               load_ok;
  logic [5:0]         p400;
  logic [8:0]         doy_ld;
  logic [15:0]        s_sum;
  logic [11:0]        q7;
  logic [14:0]        q7x7;
  logic [14:0]        wd_diff;

  assign p_ld     = ly_r - YEAR_W'(1);
  assign q400     = mul_p[24:19];
  assign q400x400 = YEAR_W'({q400, 8'b0}) + YEAR_W'({q400, 7'b0}) + YEAR_W'({q400, 4'b0});
  assign ymod_ld  = YMOD_W'(ly_r - q400x400);
  assign leap_ld  = leap_of_mod400(ymod_ld_r);
  assign load_ok  = (ly_r >= YEAR_W'(1)) && (ly_r <= MAX_Y) &&
                    (lm_r >= MONTH_W'(1)) && (lm_r <= MONTH_W'(12)) &&
                    (ld_r >= DAY_W'(1)) && (ld_r <= days_in_month(lm_r, leap_ld));
  assign p400     = mul_p[24:19];
  assign doy_ld   = days_before_month(lm_r, leap_ld);
  assign s_sum    = 16'(p_ld) + 16'(p_ld[YEAR_W-1:2]) - 16'(p100_r) + 16'(p400) +
                    16'(doy_ld) + 16'(ld_r) - 16'd1;
  assign q7       = mul_p[31:20];
  assign q7x7     = {q7, 3'b0} - 15'(q7);
  assign wd_diff  = s_r - q7x7;

  // shift arithmetic
  logic               dir_back;
  logic [AMT_W-1:0]   amt_mag;
  logic               leap_cur;
  logic [DAY_W-1:0]   dim_cur;
  logic [DAY_W-1:0]   dim_prev;
  logic               at_top;
  logic               at_bottom;
  logic               at_bound;

  assign dir_back  = amount_r[AMT_W-1];
  assign amt_mag   = dir_back ? (AMT_W'(0) - amount_r) : amount_r;
  assign leap_cur  = leap_of_mod400(ymod_r);
  assign dim_cur   = days_in_month(month_r, leap_cur);
  assign dim_prev  = days_in_month(month_r - MONTH_W'(1), leap_cur);
  assign at_top    = (day_r == DAY_W'(31)) && (month_r == MONTH_W'(12)) && (year_r == MAX_Y);
  assign at_bottom = (day_r == DAY_W'(1)) && (month_r == MONTH_W'(1)) &&
                     (year_r == YEAR_W'(1));
  assign at_bound  = dir_back ? at_bottom : at_top;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (kind_t'(in_tuser) == KIND_LOAD) ? S_LD_Q400 : S_SH_MUL;
        end
      end
      S_LD_Q400: state_nxt = S_LD_MOD;
      S_LD_MOD:  state_nxt = S_LD_P100;
      S_LD_P100: state_nxt = load_ok ? S_LD_P400 : S_DONE;
      S_LD_P400: state_nxt = S_LD_S7;
      S_LD_S7:   state_nxt = S_LD_WD;
      S_LD_WD:   state_nxt = S_DONE;
      S_SH_MUL:  state_nxt = S_SH_CNT;
      S_SH_CNT:  state_nxt = S_SH_STEP;
      S_SH_STEP: begin
        if ((cnt_r == '0) || at_bound) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: ready and multiplier operands
  always_comb begin
    in_tready = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      S_IDLE:    in_tready = 1'b1;
      S_LD_Q400: begin
        mul_a = MUL_A_W'(ly_r[YEAR_W-1:2]);
        mul_b = RECIP_100;
      end
      S_LD_MOD: begin
        mul_a = MUL_A_W'(p_ld);
        mul_b = RECIP_100;
      end
      S_LD_P100: begin
        mul_a = MUL_A_W'(p_ld[YEAR_W-1:2]);
        mul_b = RECIP_100;
      end
      S_LD_S7: begin
        mul_a = MUL_A_W'(s_r);
        mul_b = RECIP_7;
      end
      S_SH_MUL: begin
        mul_a = amt_mag;
        unique case (kind_r)
          KIND_MONTHS: mul_b = SCALE_MONTH;
          KIND_YEARS:  mul_b = SCALE_YEAR;
          default:     mul_b = SCALE_DAY;
        endcase
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture of the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r   <= kind_t'(in_tuser);
      amount_r <= in_tdata[15:0];
      ld_r     <= in_tdata[20:16];
      lm_r     <= in_tdata[24:21];
      ly_r     <= in_tdata[38:25];
    end
  end

  // load and shift working registers
  always_ff @(posedge clk) begin
    if (state_r == S_LD_MOD) begin
      ymod_ld_r <= ymod_ld;
    end
    if (state_r == S_LD_P100) begin
      p100_r <= mul_p[26:19];
    end
    if (state_r == S_LD_P400) begin
      s_r <= s_sum[14:0];
    end
    if (state_r == S_SH_CNT) begin
      cnt_r <= mul_p[CNT_W-1:0];
    end else if ((state_r == S_SH_STEP) && (cnt_r != '0) && !at_bound) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // result flags
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rej_r <= 1'b0;
      sat_r <= 1'b0;
    end else if ((state_r == S_LD_P100) && !load_ok) begin
      rej_r <= 1'b1;
    end else if ((state_r == S_SH_STEP) && (cnt_r != '0) && at_bound) begin
      sat_r <= 1'b1;
    end
  end

  // held date: load commit and one day steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= DAY_W'(1);
      month_r <= MONTH_W'(1);
      year_r  <= YEAR_W'(1);
      ymod_r  <= YMOD_W'(1);
      wd_r    <= 3'd0;
    end else if (state_r == S_LD_WD) begin
      day_r   <= ld_r;
      month_r <= lm_r;
      year_r  <= ly_r;
      ymod_r  <= ymod_ld_r;
      wd_r    <= wd_diff[2:0];
    end else if ((state_r == S_SH_STEP) && (cnt_r != '0) && !at_bound) begin
      if (!dir_back) begin
        // one day forward
        wd_r <= (wd_r == 3'd6) ? 3'd0 : wd_r + 3'd1;
        if (day_r < dim_cur) begin
          day_r <= day_r + DAY_W'(1);
        end else if (month_r < MONTH_W'(12)) begin
          day_r   <= DAY_W'(1);
          month_r <= month_r + MONTH_W'(1);
        end else begin
          day_r   <= DAY_W'(1);
          month_r <= MONTH_W'(1);
          year_r  <= year_r + YEAR_W'(1);
          ymod_r  <= (ymod_r == YMOD_W'(399)) ? '0 : ymod_r + YMOD_W'(1);
        end
      end else begin
        // one day back
        wd_r <= (wd_r == 3'd0) ? 3'd6 : wd_r - 3'd1;
        if (day_r > DAY_W'(1)) begin
          day_r <= day_r - DAY_W'(1);
        end else if (month_r > MONTH_W'(1)) begin
          day_r   <= dim_prev;
          month_r <= month_r - MONTH_W'(1);
        end else begin
          day_r   <= DAY_W'(31);
          month_r <= MONTH_W'(12);
          year_r  <= year_r - YEAR_W'(1);
          ymod_r  <= (ymod_r == '0) ? YMOD_W'(399) : ymod_r - YMOD_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_tdata_r <= {2'b00, sat_r, rej_r, WD_W'(wd_r) + WD_W'(2), leap_cur,
                      year_r, month_r, day_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// testbench for the gregorian date day stepper: directed and random transfers against a calendar predictor
module testbench;
  import gdds_pkg::*;

  // one expected result transfer
  typedef struct {
    int day;
    int month;
    int year;
    int leap;
    int weekday;
    int rejected;
    int saturated;
  } date_result_t;

  // calendar predictor with the queue of dates still to come out
  class date_scoreboard;
    int held_day;
    int held_month;
    int held_year;
    int mismatches;
    date_result_t expected_dates[$];

    function new();
      held_day = 1;
      held_month = 1;
      held_year = 1;
      mismatches = 0;
    endfunction

    function int is_leap(int y);
      return ((y % 400) == 0 || ((y % 100) != 0 && (y % 4) == 0)) ? 1 : 0;
    endfunction

    function int month_days(int m, int y);
      int len;
      case (m)
        1, 3, 5, 7, 8, 10, 12: len = 31;
        4, 6, 9, 11:           len = 30;
        2:                     len = is_leap(y) ? 29 : 28;
        default:               len = 0;
      endcase
      return len;
    endfunction

    // days elapsed from 1/1/1 up to 1/1/y
    function longint days_to_year(longint y);
      longint p;
      p = y - 1;
      return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    function longint date_ordinal(int d, int m, int y);
      longint n;
      n = days_to_year(y);
      for (int i = 1; i < m && i <= 12; i++) begin
        n += month_days(i, y);
      end
      return n + d - 1;
    endfunction

    function void set_from_ordinal(longint n);
      longint y;
      int m;
      y = 1 + n / 366;
      m = 1;
      while (days_to_year(y + 1) <= n) begin
        y++;
      end
      n -= days_to_year(y);
      while (m < 12 && n >= month_days(m, int'(y))) begin
        n -= month_days(m, int'(y));
        m++;
      end
      held_day = int'(n) + 1;
      held_month = m;
      held_year = int'(y);
    endfunction

    // work out the result of one accepted input transfer
    function void note_input(kind_t kind, int amount, int ld, int lm, int ly);
      date_result_t r;
      longint scale;
      longint top;
      longint target;
      r.rejected = 0;
      r.saturated = 0;
      if (kind == KIND_LOAD) begin
        if (ly >= 1 && ly <= int'(GDDS_MAX_YEAR) && lm >= 1 && lm <= 12 &&
            ld >= 1 && ld <= month_days(lm, ly)) begin
          held_day = ld;
          held_month = lm;
          held_year = ly;
        end else begin
          r.rejected = 1;
        end
      end else begin
        case (kind)
          KIND_DAYS:   scale = 1;
          KIND_MONTHS: scale = 30;
          default:     scale = 365;
        endcase
        top = days_to_year(longint'(GDDS_MAX_YEAR) + 1) - 1;
        target = date_ordinal(held_day, held_month, held_year) + longint'(amount) * scale;
        if (target < 0) begin
          target = 0;
          r.saturated = 1;
        end else if (target > top) begin
          target = top;
          r.saturated = 1;
        end
        set_from_ordinal(target);
      end
      r.day = held_day;
      r.month = held_month;
      r.year = held_year;
      r.leap = is_leap(held_year);
      r.weekday = int'(date_ordinal(held_day, held_month, held_year) % 7) + 2;
      expected_dates.push_back(r);
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) begin
        flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
      end
    endtask

    // compare one result transfer with the oldest expected date
    task check_result(logic [OUT_TDATA_W-1:0] data);
      date_result_t e;
      if (expected_dates.size() == 0) begin
        flag_mismatch($sformatf("result 0x%08h with nothing expected", data));
        return;
      end
      e = expected_dates.pop_front();
      compare_field("cur_day", int'(data[4:0]), e.day);
      compare_field("cur_month", int'(data[8:5]), e.month);
      compare_field("cur_year", int'(data[22:9]), e.year);
      compare_field("is_leap", int'(data[23]), e.leap);
      compare_field("weekday", int'(data[27:24]), e.weekday);
      compare_field("load_rejected", int'(data[28]), e.rejected);
      compare_field("saturated", int'(data[29]), e.saturated);
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  date_scoreboard sb = new();
  int idle_pct;
  int stall_pct;
  bit hold_pending;

  gregorian_date_day_stepper u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // offer one item and wait for its transfer
  task automatic send_item(kind_t kind, int amount, int ld, int lm, int ly);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {1'b0, 14'(ly), 4'(lm), 5'(ld), 16'(amount)};
    do @(posedge clk); while (!in_tready);
    sb.note_input(kind, amount, ld, lm, ly);
  endtask

  // hold the sender back until every expected date has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_dates.size() != 0);
  endtask

  // one random step: mostly valid loads and short shifts, some junk and bound runs
  task automatic random_item();
    int pick;
    int y;
    int m;
    int d;
    int amt;
    kind_t k;
    pick = $urandom_range(99);
    if (pick < 25) begin
      case ($urandom_range(5))
        0:       y = $urandom_range(1, 4);
        1:       y = $urandom_range(int'(GDDS_MAX_YEAR) - 3, int'(GDDS_MAX_YEAR));
        2:       y = 100 * $urandom_range(15, 24);
        default: y = $urandom_range(1, int'(GDDS_MAX_YEAR));
      endcase
      m = $urandom_range(1, 12);
      d = ($urandom_range(2) == 0) ? sb.month_days(m, y) : $urandom_range(1, sb.month_days(m, y));
      send_item(KIND_LOAD, int'($urandom_range(65535)), d, m, y);
    end else if (pick < 33) begin
      // raw load fields, often an impossible date
      send_item(KIND_LOAD, int'($urandom_range(65535)), $urandom_range(31), $urandom_range(15),
                $urandom_range(16383));
    end else if (pick < 38) begin
      // park next to a bound, then push hard into it
      k = kind_t'($urandom_range(1, 3));
      if ($urandom_range(1) == 1) begin
        send_item(KIND_LOAD, 0, $urandom_range(1, 31), 12, int'(GDDS_MAX_YEAR));
        send_item(k, $urandom_range(1, 32767), $urandom_range(31), $urandom_range(15),
                  $urandom_range(16383));
      end else begin
        send_item(KIND_LOAD, 0, $urandom_range(1, 31), 1, 1);
        send_item(k, -int'($urandom_range(1, 32768)), $urandom_range(31), $urandom_range(15),
                  $urandom_range(16383));
      end
    end else begin
      k = kind_t'($urandom_range(1, 3));
      case (k)
        KIND_DAYS:   amt = ($urandom_range(9) == 0) ? int'($urandom_range(800)) - 400
                                                    : int'($urandom_range(128)) - 64;
        KIND_MONTHS: amt = int'($urandom_range(8)) - 4;
        default:     amt = int'($urandom_range(4)) - 2;
      endcase
      send_item(k, amt, $urandom_range(31), $urandom_range(15), $urandom_range(16383));
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
      end
    end
  end

  // main sequence
  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= KIND_LOAD;
    in_tdata <= '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_pending = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bounds, rejected loads, month ends and exact landings
    send_item(KIND_DAYS, 0, 0, 0, 0);
    send_item(KIND_DAYS, -1, 0, 0, 0);
    send_item(KIND_YEARS, -32768, 31, 15, 16383);
    send_item(KIND_LOAD, 32767, 31, 12, 9999);
    send_item(KIND_DAYS, 1, 0, 0, 0);
    send_item(KIND_YEARS, 32767, 0, 0, 0);
    send_item(KIND_MONTHS, -1, 0, 0, 0);
    send_item(KIND_DAYS, 30, 0, 0, 0);
    send_item(KIND_LOAD, 0, 29, 2, 2000);
    send_item(KIND_LOAD, 0, 29, 2, 1900);
    send_item(KIND_LOAD, 0, 0, 1, 5);
    send_item(KIND_LOAD, 0, 1, 0, 5);
    send_item(KIND_LOAD, 0, 1, 13, 5);
    send_item(KIND_LOAD, 0, 31, 4, 2020);
    send_item(KIND_LOAD, 0, 1, 1, 0);
    send_item(KIND_LOAD, 0, 1, 1, 10000);
    send_item(KIND_LOAD, 0, 1, 3, 2024);
    send_item(KIND_DAYS, -1, 0, 0, 0);
    send_item(KIND_LOAD, 0, 28, 2, 2023);
    send_item(KIND_DAYS, 1, 0, 0, 0);
    send_item(KIND_LOAD, 0, 25, 12, 9999);
    send_item(KIND_MONTHS, 32767, 0, 0, 0);
    send_item(KIND_LOAD, 0, 2, 1, 2);
    send_item(KIND_DAYS, -366, 0, 0, 0);
    send_item(KIND_LOAD, 0, 1, 1, 1);
    send_item(KIND_DAYS, -32768, 0, 0, 0);
    drain_results();

    // random phases with different idling on each side
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          hold_pending = 1'b1;
        end
        1: begin
          idle_pct = 58;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 58;
        end
        default: begin
          idle_pct = 32;
          stall_pct = 32;
        end
      endcase
      repeat (165) random_item();
      drain_results();
    end

    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_dates.size() == 0) begin
      $display("[gregorian_date_day_stepper] OK");
    end else begin
      $display("[gregorian_date_day_stepper] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("[gregorian_date_day_stepper] ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/gdds_pkg.sv
rtl/gdds_mul.sv
rtl/gregorian_date_day_stepper.sv
tb/testbench.sv
